FILE: rtl/dukstep_pkg.sv
`default_nettype none
package dukstep_pkg;

  // CORDIC setup
  localparam int CORDIC_ITERATIONS = 16;
  localparam int AtanEntries       = 24;
  localparam int CordicSteps       = (CORDIC_ITERATIONS < AtanEntries) ?
                                     CORDIC_ITERATIONS : AtanEntries;
  localparam int CordicCntW        = $clog2(AtanEntries);
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // 1/(2*pi) in Q0.24
  localparam logic signed [24:0] InvTwoPi = 25'sd2670177;

  // Configuration register map
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_DAMPING   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_X   = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_Y   = 8'd3;

  // Arctangent table in 2^-32 turns
  function automatic logic signed [31:0] atan_turns(input logic [CordicCntW-1:0] idx);
    logic signed [31:0] v;
    begin
      case (idx)
        5'd0:  v = 32'sd536870912;
        5'd1:  v = 32'sd316933406;
        5'd2:  v = 32'sd167458907;
        5'd3:  v = 32'sd85004756;
        5'd4:  v = 32'sd42667331;
        5'd5:  v = 32'sd21354465;
        5'd6:  v = 32'sd10679838;
        5'd7:  v = 32'sd5340245;
        5'd8:  v = 32'sd2670163;
        5'd9:  v = 32'sd1335087;
        5'd10: v = 32'sd667544;
        5'd11: v = 32'sd333772;
        5'd12: v = 32'sd166886;
        5'd13: v = 32'sd83443;
        5'd14: v = 32'sd41722;
        5'd15: v = 32'sd20861;
        5'd16: v = 32'sd10430;
        5'd17: v = 32'sd5215;
        5'd18: v = 32'sd2608;
        5'd19: v = 32'sd1304;
        5'd20: v = 32'sd652;
        5'd21: v = 32'sd326;
        5'd22: v = 32'sd163;
        5'd23: v = 32'sd81;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction

  // Datapath multiply operations
  typedef enum logic [4:0] {
    OP_NONE, OP_AX, OP_AY, OP_AXDT, OP_AYDT, OP_VX, OP_VY, OP_SQX, OP_SQY,
    OP_MS, OP_MX, OP_MY, OP_PX1, OP_PX2, OP_PY1, OP_PY2, OP_YAW1, OP_YAW2
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CORD, S_AX, S_AY, S_AXDT, S_AYDT, S_VX, S_VY, S_SQX, S_SQY,
    S_MS, S_CHK, S_SQRT, S_LIM, S_MX, S_DVX, S_TKX, S_MY, S_DVY, S_TKY,
    S_CLAMP, S_PX1, S_PX2, S_PY1, S_PY2, S_YAW1, S_YAW2, S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    op_e  op;
    logic sqrt_go;
    logic div_take;
    logic div_y;
    logic zero_vel;
    logic clamp;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic sqrt_done;
    logic div_done;
    logic over_limit;
    logic lim_zero;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/dukstep_ctrl.sv
`default_nettype none
module dukstep_ctrl import dukstep_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence the step
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CORD;
        end
      end
      S_CORD:  if (status_i.cordic_done) state_d = S_AX;
      S_AX:    begin cmd_o.op = OP_AX;   state_d = S_AY;   end
      S_AY:    begin cmd_o.op = OP_AY;   state_d = S_AXDT; end
      S_AXDT:  begin cmd_o.op = OP_AXDT; state_d = S_AYDT; end
      S_AYDT:  begin cmd_o.op = OP_AYDT; state_d = S_VX;   end
      S_VX:    begin cmd_o.op = OP_VX;   state_d = S_VY;   end
      S_VY:    begin cmd_o.op = OP_VY;   state_d = S_SQX;  end
      S_SQX:   begin cmd_o.op = OP_SQX;  state_d = S_SQY;  end
      S_SQY:   begin cmd_o.op = OP_SQY;  state_d = S_MS;   end
      S_MS:    begin cmd_o.op = OP_MS;   state_d = S_CHK;  end
      S_CHK: begin
        if (status_i.over_limit) begin
          cmd_o.sqrt_go = 1'b1;
          state_d       = S_SQRT;
        end else begin
          state_d = S_CLAMP;
        end
      end
      S_SQRT:  if (status_i.sqrt_done) state_d = S_LIM;
      S_LIM: begin
        if (status_i.lim_zero) begin
          cmd_o.zero_vel = 1'b1;
          state_d        = S_CLAMP;
        end else begin
          state_d = S_MX;
        end
      end
      S_MX:    begin cmd_o.op = OP_MX; state_d = S_DVX; end
      S_DVX:   if (status_i.div_done) state_d = S_TKX;
      S_TKX:   begin cmd_o.div_take = 1'b1; state_d = S_MY; end
      S_MY:    begin cmd_o.op = OP_MY; state_d = S_DVY; end
      S_DVY:   if (status_i.div_done) state_d = S_TKY;
      S_TKY: begin
        cmd_o.div_take = 1'b1;
        cmd_o.div_y    = 1'b1;
        state_d        = S_CLAMP;
      end
      S_CLAMP: begin cmd_o.clamp = 1'b1; state_d = S_PX1; end
      S_PX1:   begin cmd_o.op = OP_PX1;  state_d = S_PX2;  end
      S_PX2:   begin cmd_o.op = OP_PX2;  state_d = S_PY1;  end
      S_PY1:   begin cmd_o.op = OP_PY1;  state_d = S_PY2;  end
      S_PY2:   begin cmd_o.op = OP_PY2;  state_d = S_YAW1; end
      S_YAW1:  begin cmd_o.op = OP_YAW1; state_d = S_YAW2; end
      S_YAW2:  begin cmd_o.op = OP_YAW2; state_d = S_DONE; end
      S_DONE: begin
        // commit once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/dukstep_datapath.sv
`default_nettype none
module dukstep_datapath import dukstep_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic [17:0]         time_step_i,
  input  wire logic signed [18:0]  accel_i,
  input  wire logic signed [15:0]  turn_rate_i,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output logic signed [21:0]       vel_x_o,
  output logic signed [21:0]       vel_y_o,
  output logic [15:0]              heading_o
);

  localparam logic signed [33:0] PosMax = 34'sd2147483647;
  localparam logic signed [33:0] PosMin = -34'sd2147483648;
  localparam logic signed [24:0] VelMax = 25'sd1048576;
  localparam logic signed [24:0] VelMin = -25'sd1048576;

  // Configuration registers
  logic [16:0]        damping_q;
  logic [20:0]        max_speed_q;
  logic signed [31:0] start_x_q, start_y_q;

  // Step state
  logic signed [31:0] pos_x_q, pos_y_q;
  logic signed [21:0] vel_x_q, vel_y_q;
  logic [15:0]        yaw_q;
  logic               started_q;

  // Item operands
  logic [17:0]        dt_q;
  logic signed [18:0] acc_q;
  logic signed [15:0] rate_q;

  // Intermediates
  logic signed [19:0] ax_q, ay_q;
  logic signed [37:0] axdt_q, aydt_q;
  logic signed [24:0] vx_q, vy_q;
  logic [49:0]        n2_q;
  logic               over_q;
  logic signed [21:0] vcx_q, vcy_q;
  logic signed [33:0] pacc_x_q, pacc_y_q;
  logic signed [34:0] rd_q;
  logic [15:0]        yaw_nx_q;

  // CORDIC
  logic signed [33:0]      cx_q, cy_q;
  logic signed [31:0]      cz_q;
  logic [CordicCntW-1:0]   cit_q;
  logic                    cbusy_q;
  logic [1:0]              quad_q;
  logic signed [34:0]      cos_w, sin_w;
  logic signed [33:0]      csx, csy;

  // Square root
  logic [49:0] sn_q;
  logic [26:0] srem_q;
  logic [24:0] sroot_q;
  logic [4:0]  scnt_q;
  logic        sbusy_q;
  logic [28:0] s_sh, s_trial;

  // Divider
  logic [44:0] dsh_q;
  logic [24:0] drem_q;
  logic [21:0] dq_q;
  logic [5:0]  dcnt_q;
  logic        dbusy_q;
  logic [25:0] d_sh, d_diff;

  // Shared multiplier
  logic signed [37:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [62:0] prod;
  logic signed [62:0] rnd16, rnd30, rnd33, rnd40;
  logic signed [24:0] dt_s;
  logic signed [21:0] axr_x, axr_y;
  logic signed [37:0] axdt_rx, axdt_ry;
  logic signed [23:0] vsum_x, vsum_y;
  logic [24:0]        mag_x, mag_y;
  logic signed [24:0] qext, vsel;
  logic signed [21:0] clamp_x, clamp_y;
  logic signed [31:0] pos_cx, pos_cy;

  assign dt_s = $signed({7'b0, dt_q});

  // Velocity update terms
  assign axdt_rx = axdt_q + (38'sd1 <<< 15);
  assign axdt_ry = aydt_q + (38'sd1 <<< 15);
  assign axr_x   = axdt_rx[37:16];
  assign axr_y   = axdt_ry[37:16];
  assign vsum_x  = 24'(vel_x_q) + 24'(axr_x);
  assign vsum_y  = 24'(vel_y_q) + 24'(axr_y);
  assign mag_x   = vx_q[24] ? 25'(-vx_q) : 25'(vx_q);
  assign mag_y   = vy_q[24] ? 25'(-vy_q) : 25'(vy_q);

  // Fold quadrant back onto CORDIC result
  always_comb begin
    case (quad_q)
      2'd0:    begin cos_w = 35'(cx_q);  sin_w = 35'(cy_q);  end
      2'd1:    begin cos_w = -35'(cy_q); sin_w = 35'(cx_q);  end
      2'd2:    begin cos_w = -35'(cx_q); sin_w = -35'(cy_q); end
      default: begin cos_w = 35'(cy_q); sin_w = -35'(cx_q); end
    endcase
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_AX:   begin mul_a = 38'(cos_w);  mul_b = 25'(acc_q); end
      OP_AY:   begin mul_a = 38'(sin_w);  mul_b = 25'(acc_q); end
      OP_AXDT: begin mul_a = 38'(ax_q);   mul_b = dt_s; end
      OP_AYDT: begin mul_a = 38'(ay_q);   mul_b = dt_s; end
      OP_VX:   begin mul_a = 38'(vsum_x); mul_b = $signed({8'b0, damping_q}); end
      OP_VY:   begin mul_a = 38'(vsum_y); mul_b = $signed({8'b0, damping_q}); end
      OP_SQX:  begin mul_a = 38'(vx_q);   mul_b = vx_q; end
      OP_SQY:  begin mul_a = 38'(vy_q);   mul_b = vy_q; end
      OP_MS: begin
        mul_a = $signed({17'b0, max_speed_q});
        mul_b = $signed({4'b0, max_speed_q});
      end
      OP_MX: begin
        mul_a = $signed({13'b0, mag_x});
        mul_b = $signed({4'b0, max_speed_q});
      end
      OP_MY: begin
        mul_a = $signed({13'b0, mag_y});
        mul_b = $signed({4'b0, max_speed_q});
      end
      OP_PX1:  begin mul_a = 38'(vcx_q);  mul_b = dt_s; end
      OP_PX2:  begin mul_a = axdt_q;      mul_b = dt_s; end
      OP_PY1:  begin mul_a = 38'(vcy_q);  mul_b = dt_s; end
      OP_PY2:  begin mul_a = aydt_q;      mul_b = dt_s; end
      OP_YAW1: begin mul_a = 38'(rate_q); mul_b = dt_s; end
      OP_YAW2: begin mul_a = 38'(rd_q);   mul_b = InvTwoPi; end
      default: begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  assign prod  = 63'(mul_a) * 63'(mul_b);
  assign rnd16 = prod + (63'sd1 <<< 15);
  assign rnd30 = prod + (63'sd1 <<< 29);
  assign rnd33 = prod + (63'sd1 <<< 32);
  assign rnd40 = prod + (63'sd1 <<< 39);

  // CORDIC step terms
  assign csx = cx_q >>> cit_q;
  assign csy = cy_q >>> cit_q;

  // Square root step terms
  assign s_sh    = {srem_q, sn_q[49:48]};
  assign s_trial = {2'b0, sroot_q, 2'b01};

  // Divider step terms
  assign d_sh   = {drem_q, dsh_q[44]};
  assign d_diff = d_sh - {1'b0, sroot_q};

  // Limited component with original sign
  assign qext = $signed({3'b0, dq_q});
  assign vsel = cmd_i.div_y ? vy_q : vx_q;

  // Velocity and position saturation
  assign clamp_x = (vx_q > VelMax) ? 22'(VelMax) : (vx_q < VelMin) ? 22'(VelMin) : vx_q[21:0];
  assign clamp_y = (vy_q > VelMax) ? 22'(VelMax) : (vy_q < VelMin) ? 22'(VelMin) : vy_q[21:0];
  assign pos_cx  = (pacc_x_q > PosMax) ? 32'(PosMax) :
                   (pacc_x_q < PosMin) ? 32'(PosMin) : pacc_x_q[31:0];
  assign pos_cy  = (pacc_y_q > PosMax) ? 32'(PosMax) :
                   (pacc_y_q < PosMin) ? 32'(PosMin) : pacc_y_q[31:0];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q   <= 17'd58982;
      max_speed_q <= 21'd131072;
      start_x_q   <= '0;
      start_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DAMPING:   damping_q   <= cfg_data_i[16:0];
        CFG_MAX_SPEED: max_speed_q <= cfg_data_i[20:0];
        CFG_START_X:   start_x_q   <= cfg_data_i;
        CFG_START_Y:   start_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Step state: load start position, commit results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      vel_x_q   <= '0;
      vel_y_q   <= '0;
      yaw_q     <= '0;
      started_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        started_q <= 1'b1;
        if (!started_q) begin
          pos_x_q <= start_x_q;
          pos_y_q <= start_y_q;
        end
      end
      if (cmd_i.commit) begin
        pos_x_q <= pos_cx;
        pos_y_q <= pos_cy;
        vel_x_q <= vcx_q;
        vel_y_q <= vcy_q;
        yaw_q   <= yaw_nx_q;
      end
    end
  end

  // CORDIC rotation, one iteration per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbusy_q <= 1'b0;
      cit_q   <= '0;
    end else if (cmd_i.load) begin
      cbusy_q <= 1'b1;
      cit_q   <= '0;
    end else if (cbusy_q) begin
      cit_q <= cit_q + 1'b1;
      if (cit_q == CordicCntW'(CordicSteps - 1)) cbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q   <= CordicGain;
      cy_q   <= '0;
      cz_q   <= $signed({2'b0, yaw_q[13:0], 16'b0});
      quad_q <= yaw_q[15:14];
    end else if (cbusy_q) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - csy;
        cy_q <= cy_q + csx;
        cz_q <= cz_q - atan_turns(cit_q);
      end else begin
        cx_q <= cx_q + csy;
        cy_q <= cy_q - csx;
        cz_q <= cz_q + atan_turns(cit_q);
      end
    end
  end

  // Square root, one result bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      scnt_q  <= '0;
    end else if (cmd_i.sqrt_go) begin
      sbusy_q <= 1'b1;
      scnt_q  <= '0;
    end else if (sbusy_q) begin
      scnt_q <= scnt_q + 1'b1;
      if (scnt_q == 5'd24) sbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      sn_q    <= n2_q;
      srem_q  <= '0;
      sroot_q <= '0;
    end else if (sbusy_q) begin
      sn_q <= {sn_q[47:0], 2'b00};
      if (s_sh >= s_trial) begin
        srem_q  <= 27'(s_sh - s_trial);
        sroot_q <= {sroot_q[23:0], 1'b1};
      end else begin
        srem_q  <= s_sh[26:0];
        sroot_q <= {sroot_q[23:0], 1'b0};
      end
    end
  end

  // Restoring divider by the norm, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.op == OP_MX || cmd_i.op == OP_MY) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (dcnt_q == 6'd44) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MX || cmd_i.op == OP_MY) begin
      dsh_q  <= prod[44:0];
      drem_q <= '0;
      dq_q   <= '0;
    end else if (dbusy_q) begin
      dsh_q <= {dsh_q[43:0], 1'b0};
      if (!d_diff[25]) begin
        drem_q <= d_diff[24:0];
        dq_q   <= {dq_q[20:0], 1'b1};
      end else begin
        drem_q <= d_sh[24:0];
        dq_q   <= {dq_q[20:0], 1'b0};
      end
    end
  end

  // Operand capture and multiply results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dt_q   <= time_step_i;
      acc_q  <= accel_i;
      rate_q <= turn_rate_i;
    end
    if (cmd_i.zero_vel) begin
      vx_q <= '0;
      vy_q <= '0;
    end
    if (cmd_i.div_take) begin
      if (cmd_i.div_y) vy_q <= vsel[24] ? -qext : qext;
      else             vx_q <= vsel[24] ? -qext : qext;
    end
    if (cmd_i.clamp) begin
      vcx_q <= clamp_x;
      vcy_q <= clamp_y;
    end
    case (cmd_i.op)
      OP_AX:   ax_q   <= rnd30[49:30];
      OP_AY:   ay_q   <= rnd30[49:30];
      OP_AXDT: axdt_q <= prod[37:0];
      OP_AYDT: aydt_q <= prod[37:0];
      OP_VX:   vx_q   <= rnd16[40:16];
      OP_VY:   vy_q   <= rnd16[40:16];
      OP_SQX:  n2_q   <= prod[49:0];
      OP_SQY:  n2_q   <= n2_q + prod[49:0];
      OP_MS:   over_q <= n2_q > prod[49:0];
      OP_PX1:  pacc_x_q <= 34'(pos_x_q) + 34'($signed(rnd16[39:16]));
      OP_PX2:  pacc_x_q <= pacc_x_q + 34'($signed(rnd33[54:33]));
      OP_PY1:  pacc_y_q <= 34'(pos_y_q) + 34'($signed(rnd16[39:16]));
      OP_PY2:  pacc_y_q <= pacc_y_q + 34'($signed(rnd33[54:33]));
      OP_YAW1: rd_q     <= prod[34:0];
      OP_YAW2: yaw_nx_q <= yaw_q + rnd40[55:40];
      default: ;
    endcase
  end

  assign status_o.cordic_done = !cbusy_q;
  assign status_o.sqrt_done   = !sbusy_q;
  assign status_o.div_done    = !dbusy_q;
  assign status_o.over_limit  = over_q;
  assign status_o.lim_zero    = (max_speed_q == '0) || (sroot_q == '0);

  assign pos_x_o   = pos_x_q;
  assign pos_y_o   = pos_y_q;
  assign vel_x_o   = vel_x_q;
  assign vel_y_o   = vel_y_q;
  assign heading_o = yaw_q;

endmodule
`default_nettype wire

FILE: rtl/damped_unicycle_kinematic_step.sv
`default_nettype none
// Damped unicycle step for one 2-D obstacle in Q16.16 fixed point. Each accepted
// item (time step, forward acceleration, turn rate) yields one result: position,
// velocity and heading after the step. The first item after reset starts from the
// start_x/start_y registers. Items are handled one at a time through a shared
// multiplier and iterative units. Each item waits on the 16-iteration CORDIC
// loop; when the limiter scales the velocity it also runs a square root and two
// restoring divisions, and a zero speed limit skips the divisions. The next
// item is taken only once the current result has been committed. A result
// stalled at the output holds the next commit. A finished result sits in the
// output register while the next item is taken in. Configuration is written
// through a separate valid/ready port that is always ready.
module damped_unicycle_kinematic_step import dukstep_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [17:0]         time_step_i,
  input  wire logic signed [18:0]  accel_i,
  input  wire logic signed [15:0]  turn_rate_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output logic signed [21:0]       vel_x_o,
  output logic signed [21:0]       vel_y_o,
  output logic [15:0]              heading_o
);

  cmd_t    cmd;
  status_t status;

  // Configuration beats are never stalled
  assign cfg_ready_o = 1'b1;

  dukstep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dukstep_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .time_step_i (time_step_i),
    .accel_i     (accel_i),
    .turn_rate_i (turn_rate_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .vel_x_o     (vel_x_o),
    .vel_y_o     (vel_y_o),
    .heading_o   (heading_o)
  );

endmodule
`default_nettype wire
